[rtl/iq_power_meter_squelch_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the power meter block
// clock i_clk and reset i_rst_n are taken from the scope of use
// ----------------------------------------------------------------------------
`ifndef IQ_POWER_METER_SQUELCH_ASSERT_SVH
`define IQ_POWER_METER_SQUELCH_ASSERT_SVH

// same-cycle implication
`define IPMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ipms assertion failed");

// next-cycle implication
`define IPMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ipms assertion failed");

`endif

[rtl/ipms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_pkg
// shared types, constants and helpers of the i/q power meter with squelch
// ----------------------------------------------------------------------------
package ipms_pkg;

    localparam int SMP_W   = 16;
    localparam int LVL_W   = 18;
    localparam int MTR_W   = 17;
    localparam int SQL_W   = 8;
    localparam int OFS_W   = 15;
    localparam int MANT_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int EXP_W   = 5;
    localparam int LOG_W   = EXP_W + FRAC_W;
    localparam int DB_W    = 42;

    localparam logic [17:0] LOG10_2_Q16 = 18'd197283;
    localparam logic signed [10:0] ALPHA_Q16 = 11'sd655;
    localparam logic signed [DB_W-1:0] DB_BIAS =
        DB_W'(64'd30 * 64'd65536 * 64'd197283 - 64'd8388608);

    localparam logic signed [MTR_W-1:0] FLOOR_RESET   = -17'sd30720;
    localparam logic signed [MTR_W-1:0] CEILING_RESET = 17'sd0;
    localparam logic signed [SQL_W-1:0] SQUELCH_RESET = -8'sd100;
    localparam logic signed [OFS_W-1:0] OFFSET_RESET  = 15'sd0;

    typedef enum logic [1:0] {
        CFG_SQUELCH = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_FLOOR   = 2'd2,
        CFG_CEILING = 2'd3
    } t_cfg_addr;

    // index of the top set bit of a nonzero word
    function automatic logic [EXP_W-1:0] top_bit(input logic [MANT_W-1:0] v);
        logic [MANT_W-1:0] x;
        logic [EXP_W-1:0]  e;
        x = v;
        e = '0;
        if (x[31:16] != '0) begin
            e[4] = 1'b1;
            x = x >> 16;
        end
        if (x[15:8] != '0) begin
            e[3] = 1'b1;
            x = x >> 8;
        end
        if (x[7:4] != '0) begin
            e[2] = 1'b1;
            x = x >> 4;
        end
        if (x[3:2] != '0) begin
            e[1] = 1'b1;
            x = x >> 2;
        end
        if (x[1]) begin
            e[0] = 1'b1;
        end
        return e;
    endfunction

    // limit to ceiling, then raise to floor
    function automatic logic signed [MTR_W-1:0] clamp_meter(
        input logic signed [LVL_W:0]   v,
        input logic signed [MTR_W-1:0] lo,
        input logic signed [MTR_W-1:0] hi
    );
        logic signed [LVL_W:0] x;
        logic signed [LVL_W:0] lo_x;
        logic signed [LVL_W:0] hi_x;
        x    = v;
        lo_x = {{2{lo[MTR_W-1]}}, lo};
        hi_x = {{2{hi[MTR_W-1]}}, hi};
        if (x > hi_x) begin
            x = hi_x;
        end
        if (x < lo_x) begin
            x = lo_x;
        end
        return x[MTR_W-1:0];
    endfunction

endpackage

[rtl/ipms_sq_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_sq_stage
// one fraction bit of log2: square the q31 mantissa and renormalize
// ----------------------------------------------------------------------------
module ipms_sq_stage (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [ipms_pkg::MANT_W-1:0]        i_mant,
    input  logic [ipms_pkg::FRAC_W-1:0]        i_frac,
    output logic [ipms_pkg::MANT_W-1:0]        o_mant,
    output logic [ipms_pkg::FRAC_W-1:0]        o_frac
);

    logic [2*ipms_pkg::MANT_W-1:0] w_prod;
    logic [ipms_pkg::MANT_W:0]     w_sq;
    logic [ipms_pkg::MANT_W-1:0]   n_mant;
    logic [ipms_pkg::FRAC_W-1:0]   n_frac;
    logic [ipms_pkg::MANT_W-1:0]   r_mant;
    logic [ipms_pkg::FRAC_W-1:0]   r_frac;

    always_comb begin
        w_prod = i_mant * i_mant;
        w_sq   = w_prod[2*ipms_pkg::MANT_W-1:ipms_pkg::MANT_W-1];
        if (w_sq[ipms_pkg::MANT_W]) begin
            n_mant = w_sq[ipms_pkg::MANT_W:1];
        end else begin
            n_mant = w_sq[ipms_pkg::MANT_W-1:0];
        end
        n_frac = {i_frac[ipms_pkg::FRAC_W-2:0], w_sq[ipms_pkg::MANT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mant <= n_mant;
            r_frac <= n_frac;
        end
    end

    assign o_mant = r_mant;
    assign o_frac = r_frac;

endmodule

[rtl/iq_power_meter_squelch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_power_meter_squelch
// i/q power meter in q8.8 db with exponential average and squelch gate
// ----------------------------------------------------------------------------
// pipeline: 23 stage registers from input transfer to result valid, of which 16
// form the squaring chain that produces the log2 fraction
// throughput: one sample per cycle while m_tready does not stall the output, every
// stage is registered and stalls collapse bubbles stage by stage
// reset: synchronous, clears all stage valids, sets the average to -120 db
// and the registers to their reset values
module iq_power_meter_squelch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_i, sample_q
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // gated_i, gated_q, instant_meter, average_meter, pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int S_IN  = 0;
    localparam int S_POW = 1;
    localparam int S_EXP = 2;
    localparam int S_NRM = 3;
    localparam int S_SQ0 = 4;
    localparam int N_SQ  = ipms_pkg::FRAC_W;
    localparam int S_LVL = S_SQ0 + N_SQ;
    localparam int S_AVG = S_LVL + 1;
    localparam int S_OUT = S_AVG + 1;
    localparam int N_STG = S_OUT + 1;

    localparam int SW = ipms_pkg::SMP_W;
    localparam int LW = ipms_pkg::LVL_W;
    localparam int MW = ipms_pkg::MTR_W;

    // configuration registers
    logic signed [ipms_pkg::SQL_W-1:0] r_squelch;
    logic signed [ipms_pkg::OFS_W-1:0] r_offset;
    logic signed [MW-1:0]              r_floor;
    logic signed [MW-1:0]              r_ceiling;
    logic                              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squelch <= ipms_pkg::SQUELCH_RESET;
            r_offset  <= ipms_pkg::OFFSET_RESET;
            r_floor   <= ipms_pkg::FLOOR_RESET;
            r_ceiling <= ipms_pkg::CEILING_RESET;
        end else if (w_wr) begin
            unique case (ipms_pkg::t_cfg_addr'(paddr[3:2]))
                ipms_pkg::CFG_SQUELCH: r_squelch <= pwdata[ipms_pkg::SQL_W-1:0];
                ipms_pkg::CFG_OFFSET:  r_offset  <= pwdata[ipms_pkg::OFS_W-1:0];
                ipms_pkg::CFG_FLOOR:   r_floor   <= pwdata[MW-1:0];
                ipms_pkg::CFG_CEILING: r_ceiling <= pwdata[MW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (ipms_pkg::t_cfg_addr'(paddr[3:2]))
            ipms_pkg::CFG_SQUELCH: prdata = {{(32-ipms_pkg::SQL_W){r_squelch[7]}}, r_squelch};
            ipms_pkg::CFG_OFFSET:  prdata = {{(32-ipms_pkg::OFS_W){r_offset[14]}}, r_offset};
            ipms_pkg::CFG_FLOOR:   prdata = {{(32-MW){r_floor[MW-1]}}, r_floor};
            ipms_pkg::CFG_CEILING: prdata = {{(32-MW){r_ceiling[MW-1]}}, r_ceiling};
        endcase
    end

    // stage handshake
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_rdy;
    logic [N_STG-1:0] w_load;

    always_comb begin
        w_rdy[N_STG-1] = !r_vld[N_STG-1] | m_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] | w_rdy[k+1];
        end
        w_load[0] = s_tvalid & w_rdy[0];
        for (int k = 1; k < N_STG; k++) begin
            w_load[k] = r_vld[k-1] & w_rdy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_tready = w_rdy[0];

    // sample and flags carried down the pipe
    logic signed [SW-1:0]            r_si   [N_STG-1];
    logic signed [SW-1:0]            r_sq   [N_STG-1];
    logic                            r_zero [N_STG-1];
    logic [ipms_pkg::EXP_W-1:0]      r_exp  [N_STG-1];
    logic [ipms_pkg::MANT_W-1:0]     r_pow;
    logic [ipms_pkg::MANT_W-1:0]     r_pow2;
    logic [ipms_pkg::MANT_W-1:0]     n_pow;
    logic [SW*2:0]                   w_pow_sum;

    always_comb begin
        w_pow_sum = (SW*2+1)'($signed(r_si[S_IN]) * $signed(r_si[S_IN]))
                  + (SW*2+1)'($signed(r_sq[S_IN]) * $signed(r_sq[S_IN]));
        n_pow = w_pow_sum[ipms_pkg::MANT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_load[S_IN]) begin
            r_si[S_IN] <= s_tdata[SW-1:0];
            r_sq[S_IN] <= s_tdata[2*SW-1:SW];
        end
        for (int k = 1; k < N_STG - 1; k++) begin
            if (w_load[k]) begin
                r_si[k] <= r_si[k-1];
                r_sq[k] <= r_sq[k-1];
                if (k == S_POW) begin
                    r_zero[k] <= (n_pow == '0);
                end else begin
                    r_zero[k] <= r_zero[k-1];
                end
                if (k == S_EXP) begin
                    r_exp[k] <= ipms_pkg::top_bit(r_pow);
                end else if (k > S_EXP) begin
                    r_exp[k] <= r_exp[k-1];
                end
            end
        end
        if (w_load[S_POW]) begin
            r_pow <= n_pow;
        end
        if (w_load[S_EXP]) begin
            r_pow2 <= r_pow;
        end
    end

    // normalize to q31 mantissa
    logic [ipms_pkg::MANT_W-1:0] w_mant [N_SQ+1];
    logic [ipms_pkg::FRAC_W-1:0] w_frac [N_SQ+1];
    logic [ipms_pkg::MANT_W-1:0] r_mant;
    logic [ipms_pkg::EXP_W-1:0]  w_shift;

    assign w_shift = ipms_pkg::EXP_W'(ipms_pkg::MANT_W - 1) - r_exp[S_EXP];

    always_ff @(posedge i_clk) begin
        if (w_load[S_NRM]) begin
            r_mant <= r_pow2 << w_shift;
        end
    end

    assign w_mant[0] = r_mant;
    assign w_frac[0] = '0;

    for (genvar j = 0; j < N_SQ; j++) begin : g_sq
        ipms_sq_stage u_sq (
            .i_clk  (i_clk),
            .i_load (w_load[S_SQ0+j]),
            .i_mant (w_mant[j]),
            .i_frac (w_frac[j]),
            .o_mant (w_mant[j+1]),
            .o_frac (w_frac[j+1])
        );
    end

    // log2 to db
    logic [ipms_pkg::LOG_W-1:0]          w_log2;
    logic [ipms_pkg::LOG_W+17:0]         w_db_prod;
    logic signed [ipms_pkg::DB_W-1:0]    w_db;
    logic signed [LW-1:0]                n_level;
    logic signed [LW-1:0]                r_lvl_a;
    logic signed [LW-1:0]                r_lvl_b;

    always_comb begin
        w_log2    = {r_exp[S_LVL-1], w_frac[N_SQ]};
        w_db_prod = w_log2 * ipms_pkg::LOG10_2_Q16;
        w_db      = $signed({3'b000, w_db_prod}) - ipms_pkg::DB_BIAS;
        if (r_zero[S_LVL-1]) begin
            n_level = {r_floor[MW-1], r_floor};
        end else begin
            n_level = w_db[LW+23:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[S_LVL]) begin
            r_lvl_a <= n_level;
        end
        if (w_load[S_AVG]) begin
            r_lvl_b <= r_lvl_a;
        end
    end

    // exponential average
    logic signed [LW-1:0] r_average;
    logic signed [LW-1:0] r_avg_b;
    logic signed [LW:0]   w_delta;
    logic signed [30:0]   w_scaled;
    logic signed [14:0]   w_step;
    logic signed [LW-1:0] n_average;

    always_comb begin
        w_delta   = {r_lvl_a[LW-1], r_lvl_a} - {r_average[LW-1], r_average};
        w_scaled  = 31'(w_delta * ipms_pkg::ALPHA_Q16) + 31'sd32768;
        w_step    = w_scaled[30:16];
        n_average = r_average + {{(LW-15){w_step[14]}}, w_step};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average <= {ipms_pkg::FLOOR_RESET[MW-1], ipms_pkg::FLOOR_RESET};
        end else if (w_load[S_AVG]) begin
            r_average <= n_average;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[S_AVG]) begin
            r_avg_b <= n_average;
        end
    end

    // gate and meters
    logic                 w_mute;
    logic signed [LW:0]   w_inst_ofs;
    logic signed [LW:0]   w_avg_ofs;
    logic signed [LW-1:0] w_sql_lvl;
    logic signed [SW-1:0] r_gi;
    logic signed [SW-1:0] r_gq;
    logic signed [MW-1:0] r_im;
    logic signed [MW-1:0] r_am;

    always_comb begin
        w_sql_lvl  = {{(LW-ipms_pkg::SQL_W-8){r_squelch[7]}}, r_squelch, 8'h00};
        w_mute     = r_avg_b < w_sql_lvl;
        w_inst_ofs = {r_lvl_b[LW-1], r_lvl_b}
                   + {{(LW+1-ipms_pkg::OFS_W){r_offset[14]}}, r_offset};
        w_avg_ofs  = {r_avg_b[LW-1], r_avg_b}
                   + {{(LW+1-ipms_pkg::OFS_W){r_offset[14]}}, r_offset};
    end

    always_ff @(posedge i_clk) begin
        if (w_load[S_OUT]) begin
            r_gi <= w_mute ? '0 : r_si[S_AVG];
            r_gq <= w_mute ? '0 : r_sq[S_AVG];
            r_im <= ipms_pkg::clamp_meter(w_inst_ofs, r_floor, r_ceiling);
            r_am <= ipms_pkg::clamp_meter(w_avg_ofs, r_floor, r_ceiling);
        end
    end

    assign m_tvalid = r_vld[S_OUT];
    assign m_tdata  = {6'b0, r_am, r_im, r_gq, r_gi};

endmodule

[rtl/ipms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipms_checker
// port-level checks of the power meter, bound to the top level
// ----------------------------------------------------------------------------
`include "iq_power_meter_squelch_assert.svh"

module ipms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // no result left over from before reset
    `IPMS_ASSERT_IMP(a_rst_empty, !$past(i_rst_n), !m_tvalid)

    // an empty output slot lets the whole pipe move
    `IPMS_ASSERT_IMP(a_rdy_empty, !m_tvalid, s_tready)

    `IPMS_ASSERT_NXT(a_vld_hold, m_tvalid && !m_tready, m_tvalid)

    `IPMS_ASSERT_NXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind iq_power_meter_squelch ipms_checker u_ipms_checker (.*);
